FILE: rtl/usbtd_pkg.sv
`default_nettype none
package usbtd_pkg;

  localparam int MAX_TDS_DEFAULT = 64;
  localparam int CMDQ_DEPTH_DEFAULT = 2;

  localparam int PKT_W = 7;
  localparam int LEN_W = 12;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 7;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_PKT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BULK_PKT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BULK_TOGGLE = 2'd2;

  localparam logic [PKT_W-1:0] CONTROL_PKT_RESET = 7'd8;
  localparam logic [PKT_W-1:0] BULK_PKT_RESET    = 7'd64;
  localparam logic [PKT_W-1:0] PKT_MAX           = 7'd64;
  localparam logic             BULK_TOGGLE_RESET = 1'b1;

  localparam logic [LEN_W-1:0] CONTROL_MAX_LEN = 12'd2048;
  localparam logic [LEN_W-1:0] BULK_MAX_LEN    = 12'd3072;

  localparam logic [7:0] PID_SETUP = 8'h2D;
  localparam logic [7:0] PID_IN    = 8'h69;
  localparam logic [7:0] PID_OUT   = 8'hE1;

  localparam logic [10:0] NULL_LEN  = 11'h7FF;
  localparam logic [10:0] SETUP_LEN = 11'd7;

  localparam logic [31:0] CTL_ACTIVE = 32'h0080_0000;
  localparam logic [31:0] CTL_IOC    = 32'h0100_0000;
  localparam logic [31:0] CTL_LS     = 32'h0400_0000;
  localparam logic [31:0] CTL_CERR3  = 32'h1800_0000;

  localparam logic [LEN_W-1:0] DATA_BASE  = 12'h400;
  localparam logic [LEN_W-1:0] STATUS_BUF = 12'h300;

  typedef struct packed {
    logic             xfer_kind;
    logic [6:0]       device_address;
    logic [3:0]       endpoint_number;
    logic             direction_in;
    logic             ls_device;
    logic [LEN_W-1:0] byte_length;
  } req_t;

  typedef struct packed {
    logic [31:0]      td_token;
    logic [31:0]      td_control;
    logic [LEN_W-1:0] buffer_offset;
    logic             last_td;
    logic             length_error;
  } td_t;

  // classified request handed from front to back
  typedef struct packed {
    logic             bulk;
    logic [6:0]       addr;
    logic [3:0]       ep;
    logic             dir_in;
    logic             ls;
    logic [LEN_W-1:0] len;
    logic [PKT_W-1:0] pkt;
    logic             first_toggle;
    logic             err;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DATA,
    ST_STATUS,
    ST_ERROR
  } back_state_t;

  function automatic logic [31:0] make_token(
    input logic [10:0] maxlen,
    input logic        toggle,
    input logic [3:0]  ep,
    input logic [6:0]  addr,
    input logic [7:0]  pid
  );
    return {maxlen, 1'b0, toggle, ep, addr, pid};
  endfunction

  function automatic logic [PKT_W-1:0] clamp_pkt(input logic [PKT_W-1:0] v);
    logic [PKT_W-1:0] r;
    r = v;
    if (v == '0) r = 7'd1;
    else if (v > PKT_MAX) r = PKT_MAX;
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/usbtd_front.sv
`default_nettype none
module usbtd_front #(
  parameter int MAX_TDS = usbtd_pkg::MAX_TDS_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [usbtd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [usbtd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire logic                               in_push,
  input  wire usbtd_pkg::req_t                    in_data,
  input  wire logic                               q_full,
  output logic                                    q_push,
  output usbtd_pkg::cmd_t                         q_data
);

  localparam int TdW   = $clog2(MAX_TDS + 1);
  localparam int ProdW = TdW + usbtd_pkg::PKT_W;
  localparam int CmpW  = (ProdW > usbtd_pkg::LEN_W) ? ProdW : usbtd_pkg::LEN_W;
  localparam logic [TdW-1:0] LimBulk = TdW'(MAX_TDS);
  localparam logic [TdW-1:0] LimCtl  = TdW'(MAX_TDS - 2);

  logic [usbtd_pkg::PKT_W-1:0] ctl_pkt_r;
  logic [usbtd_pkg::PKT_W-1:0] blk_pkt_r;
  logic                        blk_tog_r;

  logic [usbtd_pkg::PKT_W-1:0] pkt;
  logic [TdW-1:0]              lim;
  logic [ProdW-1:0]            span;
  logic                        too_many;
  logic                        bad_len;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_pkt_r <= usbtd_pkg::CONTROL_PKT_RESET;
      blk_pkt_r <= usbtd_pkg::BULK_PKT_RESET;
      blk_tog_r <= usbtd_pkg::BULK_TOGGLE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        usbtd_pkg::CFG_CONTROL_PKT: ctl_pkt_r <= cfg_wdata;
        usbtd_pkg::CFG_BULK_PKT:    blk_pkt_r <= cfg_wdata;
        usbtd_pkg::CFG_BULK_TOGGLE: blk_tog_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // ceil(len / pkt) > lim holds exactly when len > lim * pkt
  always_comb begin
    pkt  = usbtd_pkg::clamp_pkt(in_data.xfer_kind ? blk_pkt_r : ctl_pkt_r);
    lim  = in_data.xfer_kind ? LimBulk : LimCtl;
    span = ProdW'(lim) * ProdW'(pkt);
    too_many = CmpW'(in_data.byte_length) > CmpW'(span);
    if (in_data.xfer_kind)
      bad_len = (in_data.byte_length == '0) ||
                (in_data.byte_length > usbtd_pkg::BULK_MAX_LEN);
    else
      bad_len = in_data.byte_length > usbtd_pkg::CONTROL_MAX_LEN;
  end

  always_comb begin
    q_push              = in_push && !q_full;
    q_data.bulk         = in_data.xfer_kind;
    q_data.addr         = in_data.device_address;
    q_data.ep           = in_data.endpoint_number;
    q_data.dir_in       = in_data.direction_in;
    q_data.ls           = in_data.ls_device;
    q_data.len          = in_data.byte_length;
    q_data.pkt          = pkt;
    q_data.first_toggle = blk_tog_r;
    q_data.err          = bad_len || too_many;
  end

endmodule
`default_nettype wire

FILE: rtl/usbtd_cmdq.sv
`default_nettype none
module usbtd_cmdq #(
  parameter int DEPTH = usbtd_pkg::CMDQ_DEPTH_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire usbtd_pkg::cmd_t  wr_data,
  output logic                  full,
  input  wire logic             pop,
  output usbtd_pkg::cmd_t       rd_data,
  output logic                  empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  usbtd_pkg::cmd_t entry_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            do_push, do_pop;

  always_comb begin
    full    = count_r == FullCnt;
    empty   = count_r == '0;
    do_push = push && !full;
    do_pop  = pop && !empty;
    rd_data = entry_r[rd_ptr_r];
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entry_r[wr_ptr_r] <= wr_data;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FullCnt) else $error("command queue count past depth");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r)) else $error("empty queue with pointer gap");
  a_pop_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && !do_push) |=> (count_r == $past(count_r) - 1'b1))
    else $error("pop did not drain queue");
`endif

endmodule
`default_nettype wire

FILE: rtl/usbtd_back.sv
`default_nettype none
module usbtd_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_empty,
  input  wire usbtd_pkg::cmd_t  q_data,
  output logic                  q_pop,
  output logic                  out_empty,
  input  wire logic             out_pop,
  output usbtd_pkg::td_t        out_data
);

  usbtd_pkg::back_state_t state_r, state_nxt;
  usbtd_pkg::cmd_t        cmd_r, cmd_nxt;
  logic [usbtd_pkg::LEN_W-1:0] off_r, off_nxt;
  logic                        tog_r, tog_nxt;
  usbtd_pkg::td_t              out_r;
  logic                        out_valid_r;

  logic                        adv;
  logic                        emit;
  usbtd_pkg::td_t              desc;
  logic [usbtd_pkg::LEN_W-1:0] rem;
  logic                        last_pkt;
  logic [usbtd_pkg::PKT_W-1:0] sz;
  logic [31:0]                 ctl_word;
  logic [7:0]                  pkt_pid;
  logic [7:0]                  status_pid;
  logic [3:0]                  data_ep;

  always_comb begin
    adv        = !out_valid_r || out_pop;
    rem        = cmd_r.len - off_r;
    last_pkt   = rem <= usbtd_pkg::LEN_W'(cmd_r.pkt);
    sz         = last_pkt ? rem[usbtd_pkg::PKT_W-1:0] : cmd_r.pkt;
    ctl_word   = usbtd_pkg::CTL_ACTIVE | usbtd_pkg::CTL_CERR3 |
                 ((cmd_r.ls && !cmd_r.bulk) ? usbtd_pkg::CTL_LS : 32'h0);
    pkt_pid    = cmd_r.dir_in ? usbtd_pkg::PID_IN : usbtd_pkg::PID_OUT;
    status_pid = cmd_r.dir_in ? usbtd_pkg::PID_OUT : usbtd_pkg::PID_IN;
    data_ep    = cmd_r.bulk ? cmd_r.ep : 4'd0;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      usbtd_pkg::ST_IDLE: begin
        if (!q_empty) begin
          if (q_data.err) state_nxt = usbtd_pkg::ST_ERROR;
          else if (q_data.bulk) state_nxt = usbtd_pkg::ST_DATA;
          else state_nxt = usbtd_pkg::ST_SETUP;
        end
      end
      usbtd_pkg::ST_SETUP: begin
        if (adv) state_nxt = (cmd_r.len == '0) ? usbtd_pkg::ST_STATUS : usbtd_pkg::ST_DATA;
      end
      usbtd_pkg::ST_DATA: begin
        if (adv && last_pkt) state_nxt = cmd_r.bulk ? usbtd_pkg::ST_IDLE : usbtd_pkg::ST_STATUS;
      end
      usbtd_pkg::ST_STATUS: begin
        if (adv) state_nxt = usbtd_pkg::ST_IDLE;
      end
      usbtd_pkg::ST_ERROR: begin
        if (adv) state_nxt = usbtd_pkg::ST_IDLE;
      end
      default: state_nxt = usbtd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop   = 1'b0;
    emit    = 1'b0;
    desc    = '0;
    cmd_nxt = cmd_r;
    off_nxt = off_r;
    tog_nxt = tog_r;
    case (state_r)
      usbtd_pkg::ST_IDLE: begin
        q_pop   = !q_empty;
        cmd_nxt = q_data;
        off_nxt = '0;
        tog_nxt = q_data.bulk ? q_data.first_toggle : 1'b1;
      end
      usbtd_pkg::ST_SETUP: begin
        emit = adv;
        desc.td_token = usbtd_pkg::make_token(usbtd_pkg::SETUP_LEN, 1'b0, 4'd0,
                                              cmd_r.addr, usbtd_pkg::PID_SETUP);
        desc.td_control = ctl_word;
      end
      usbtd_pkg::ST_DATA: begin
        emit = adv;
        desc.td_token = usbtd_pkg::make_token(11'(sz - 1'b1), tog_r, data_ep,
                                              cmd_r.addr, pkt_pid);
        desc.td_control    = ctl_word;
        desc.buffer_offset = usbtd_pkg::DATA_BASE + off_r;
        desc.last_td       = cmd_r.bulk && last_pkt;
        if (adv) begin
          off_nxt = off_r + usbtd_pkg::LEN_W'(sz);
          tog_nxt = ~tog_r;
        end
      end
      usbtd_pkg::ST_STATUS: begin
        emit = adv;
        desc.td_token = usbtd_pkg::make_token(usbtd_pkg::NULL_LEN, 1'b1, 4'd0,
                                              cmd_r.addr, status_pid);
        desc.td_control    = ctl_word | usbtd_pkg::CTL_IOC;
        desc.buffer_offset = usbtd_pkg::STATUS_BUF;
        desc.last_td       = 1'b1;
      end
      usbtd_pkg::ST_ERROR: begin
        emit = adv;
        desc.last_td      = 1'b1;
        desc.length_error = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= usbtd_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) out_valid_r <= 1'b1;
      else if (out_pop) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    off_r <= off_nxt;
    tog_r <= tog_nxt;
    if (emit) out_r <= desc;
  end

  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == usbtd_pkg::ST_IDLE)) else $error("queue read while busy");
  a_data_off: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == usbtd_pkg::ST_DATA) |-> (off_r < cmd_r.len)) else $error("data past length");
  a_setup_ctl: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == usbtd_pkg::ST_SETUP) |-> !cmd_r.bulk) else $error("setup on bulk request");
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.length_error) |-> out_r.last_td) else $error("error word not last");
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_pop) |-> !emit) else $error("output word overwritten");
`endif

endmodule
`default_nettype wire

FILE: rtl/usb_td_chain_builder.sv
`default_nettype none
// UHCI transfer descriptor chain builder. Each request word pushed on the
// input queue expands into its chain of descriptor words on the output queue:
// for control, a SETUP descriptor, the data packets with alternating toggle and
// a status descriptor with IOC; for bulk, the data packets alone. A request
// that cannot be built yields a single word with length_error and last_td set.
// The front classifies a request in the cycle it is pushed (length limits and
// chain length against MAX_TDS, checked with one multiply), then parks it in a
// CMDQ_DEPTH-deep command queue. The back sequencer loads one request in its
// idle state and then issues one descriptor per cycle while the output is
// popped every cycle, up to MAX_TDS descriptors per request; while a word sits
// unpopped in the output register the sequencer holds. Write the packet size
// and toggle registers only while no request is in flight.
module usb_td_chain_builder #(
  parameter int MAX_TDS    = usbtd_pkg::MAX_TDS_DEFAULT,
  parameter int CMDQ_DEPTH = usbtd_pkg::CMDQ_DEPTH_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [usbtd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [usbtd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire logic                               in_push,
  output logic                                    in_full,
  input  wire usbtd_pkg::req_t                    in_data,
  output logic                                    out_empty,
  input  wire logic                               out_pop,
  output usbtd_pkg::td_t                          out_data
);

  logic            q_push;
  usbtd_pkg::cmd_t q_wr_data;
  logic            q_full;
  logic            q_pop;
  usbtd_pkg::cmd_t q_rd_data;
  logic            q_empty;

  // classify requests and hold the configuration registers
  usbtd_front #(
    .MAX_TDS (MAX_TDS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_push   (in_push),
    .in_data   (in_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wr_data)
  );

  // decouple classification from descriptor issue
  usbtd_cmdq #(
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  // walk each request's chain, one descriptor word per cycle while the output is popped
  usbtd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_rd_data),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  // full back-pressures the request side directly
  assign in_full = q_full;

endmodule
`default_nettype wire
